>>> rtl/ast_pkg.sv
// shared types and constants for the access point scan table
package ast_pkg;

    localparam int CHW = 8;
    localparam int OW  = 7;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_CLEAR  = 2'd0;
    localparam t_cmd CMD_RECORD = 2'd1;
    localparam t_cmd CMD_QUERY  = 2'd2;
    localparam t_cmd CMD_NOP    = 2'd3;

    localparam logic [CHW-1:0] BAND5_FIRST = 8'd36;
    localparam logic [OW-1:0]  NONE_INDEX  = 7'h7F;

    // one table entry as it travels along the ring
    typedef struct packed {
        logic [47:0]       addr;
        logic [CHW-1:0]    chan;
        logic signed [7:0] sig;
        logic [31:0]       sec;
        logic              named;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK1,
        S_WALK2,
        S_DONE
    } t_state;

endpackage

>>> rtl/ap_scan_table_core.sv
// access point scan table: controller and ring of entry cells
//
// channel | handshake          | payload
// in      | i_valid / o_ready  | i_command i_bssid i_channel i_rssi i_security_code
//         |                    | i_name_length i_query_band
// out     | o_valid / i_ready  | o_entry_index o_is_new o_dropped_full o_name_uncloaked
//         |                    | o_total_count o_band_count o_strongest_index
//         |                    | o_busiest_channel o_channel_count
//
// clear and no operation need no walk, a record walks the ring once and a query
// twice; each walk rotates the whole ring once past the head cell.
// one item is worked at a time; a new item is taken while a result waits.
// reset empties the table; entry contents need no clearing.
// a stalled result holds the controller in its final state until taken.
module ap_scan_table_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [47:0] i_bssid,
    input  logic [7:0]  i_channel,
    input  logic signed [7:0] i_rssi,
    input  logic [31:0] i_security_code,
    input  logic [7:0]  i_name_length,
    input  logic        i_query_band,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [6:0] o_entry_index,
    output logic        o_is_new,
    output logic        o_dropped_full,
    output logic        o_name_uncloaked,
    output logic [6:0]  o_total_count,
    output logic [6:0]  o_band_count,
    output logic signed [6:0] o_strongest_index,
    output logic [7:0]  o_busiest_channel,
    output logic [6:0]  o_channel_count
);
    import ast_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_state r_state, n_state;

    t_cmd              r_cmd;
    logic [47:0]       r_key;
    logic [7:0]        r_chan;
    logic signed [7:0] r_sig;
    logic [31:0]       r_sec;
    logic              r_has_name;
    logic              r_band;

    logic [IW-1:0] r_step;
    logic [CW-1:0] r_total;
    logic          r_found, r_append, r_uncloak;
    logic [IW-1:0] r_idx;
    logic [CW-1:0] r_band_cnt, r_ch_cnt, r_best_cnt;
    logic          r_best_valid;
    logic [IW-1:0] r_best_idx;
    logic signed [7:0] r_best_sig;
    logic [7:0]    r_busiest;

    logic          r_out_valid;
    logic [OW-1:0] r_o_idx, r_o_total, r_o_band, r_o_strong, r_o_chcnt;
    logic          r_o_new, r_o_drop, r_o_uncl;
    logic [7:0]    r_o_busy;

    t_entry        ring_entry [TABLE_DEPTH];
    logic [CW-1:0] ring_cnt   [TABLE_DEPTH];
    t_entry        fb_entry;

    logic       accept, out_free, last_step, head_valid, head_match, head_band;
    logic       shift, bc_en, clr_cnt, is_append_slot;
    t_entry     head;

    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign head     = ring_entry[0];
    assign last_step  = (r_step == IW'(TABLE_DEPTH - 1));
    assign head_valid = (CW'(r_step) < r_total);
    assign head_match = head_valid && (head.addr == r_key);
    assign head_band  = r_band ? (head.chan >= BAND5_FIRST) : (head.chan < BAND5_FIRST);
    assign is_append_slot = (CW'(r_step) == r_total) && !r_found
                            && (r_total < CW'(TABLE_DEPTH));

    // ring of cells, head at index zero, feedback enters the last cell
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        t_entry        nb_entry;
        logic [CW-1:0] nb_cnt;
        if (g == TABLE_DEPTH - 1) begin : g_tail
            assign nb_entry = fb_entry;
            assign nb_cnt   = ring_cnt[0];
        end else begin : g_mid
            assign nb_entry = ring_entry[g+1];
            assign nb_cnt   = ring_cnt[g+1];
        end
        ast_cell #(.CW(CW)) u_cell (
            .i_clk     (i_clk),
            .i_shift   (shift),
            .i_clr_cnt (clr_cnt),
            .i_bc_en   (bc_en),
            .i_bc_chan (head.chan),
            .i_entry   (nb_entry),
            .i_cnt     (nb_cnt),
            .o_entry   (ring_entry[g]),
            .o_cnt     (ring_cnt[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_command == CMD_RECORD || i_command == CMD_QUERY) begin
                        n_state = S_WALK1;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_WALK1: begin
                if (last_step) begin
                    n_state = (r_cmd == CMD_QUERY) ? S_WALK2 : S_DONE;
                end
            end
            S_WALK2: begin
                if (last_step) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ring control and write-back of the head entry
    always_comb begin
        o_ready  = (r_state == S_IDLE);
        shift    = (r_state == S_WALK1) || (r_state == S_WALK2);
        clr_cnt  = (r_state == S_IDLE);
        bc_en    = (r_state == S_WALK1) && (r_cmd == CMD_QUERY) && head_valid;
        fb_entry = head;
        if (r_state == S_WALK1 && r_cmd == CMD_RECORD) begin
            if (head_match) begin
                fb_entry.chan  = r_chan;
                fb_entry.sig   = r_sig;
                fb_entry.sec   = r_sec;
                fb_entry.named = head.named || r_has_name;
            end else if (is_append_slot) begin
                fb_entry.addr  = r_key;
                fb_entry.chan  = r_chan;
                fb_entry.sig   = r_sig;
                fb_entry.sec   = r_sec;
                fb_entry.named = r_has_name;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            r_state <= n_state;
            if (accept && i_command == CMD_CLEAR) r_total <= '0;
            if (shift) begin
                r_step <= last_step ? '0 : r_step + IW'(1);
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
                if (r_cmd == CMD_RECORD && r_append) r_total <= r_total + CW'(1);
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item fields and walk results
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd        <= i_command;
            r_key        <= i_bssid;
            r_chan       <= i_channel;
            r_sig        <= i_rssi;
            r_sec        <= i_security_code;
            r_has_name   <= (i_name_length != 8'd0);
            r_band       <= i_query_band;
            r_found      <= 1'b0;
            r_append     <= 1'b0;
            r_uncloak    <= 1'b0;
            r_idx        <= '0;
            r_band_cnt   <= '0;
            r_ch_cnt     <= '0;
            r_best_cnt   <= '0;
            r_best_valid <= 1'b0;
            r_best_idx   <= '0;
            r_best_sig   <= '0;
            r_busiest    <= '0;
        end else if (r_state == S_WALK1) begin
            if (head_match) begin
                r_found <= 1'b1;
                r_idx   <= r_step;
                if (r_cmd == CMD_RECORD && !head.named && r_has_name) r_uncloak <= 1'b1;
            end else if (r_cmd == CMD_RECORD && is_append_slot) begin
                r_append <= 1'b1;
                r_idx    <= r_step;
            end
            if (r_cmd == CMD_QUERY && head_valid) begin
                if (head.chan == r_chan) r_ch_cnt <= r_ch_cnt + CW'(1);
                if (head_band) begin
                    r_band_cnt <= r_band_cnt + CW'(1);
                    if (!r_best_valid || (head.sig > r_best_sig)) begin
                        r_best_valid <= 1'b1;
                        r_best_idx   <= r_step;
                        r_best_sig   <= head.sig;
                    end
                end
            end
        end else if (r_state == S_WALK2) begin
            // first in-band entry whose channel has a strictly larger count
            if (head_valid && head_band && (ring_cnt[0] > r_best_cnt)) begin
                r_best_cnt <= ring_cnt[0];
                r_busiest  <= head.chan;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_o_idx    <= (r_found || r_append) ? OW'(r_idx) : NONE_INDEX;
            r_o_new    <= 1'b0;
            r_o_drop   <= 1'b0;
            r_o_uncl   <= 1'b0;
            r_o_total  <= OW'(r_total);
            r_o_band   <= '0;
            r_o_strong <= NONE_INDEX;
            r_o_busy   <= '0;
            r_o_chcnt  <= '0;
            case (r_cmd)
                CMD_RECORD: begin
                    r_o_new   <= r_append;
                    r_o_drop  <= !r_found && !r_append;
                    r_o_uncl  <= r_uncloak;
                    r_o_total <= r_append ? OW'(r_total + CW'(1)) : OW'(r_total);
                end
                CMD_QUERY: begin
                    r_o_band   <= OW'(r_band_cnt);
                    r_o_strong <= r_best_valid ? OW'(r_best_idx) : NONE_INDEX;
                    r_o_busy   <= r_busiest;
                    r_o_chcnt  <= OW'(r_ch_cnt);
                end
                default: begin
                    r_o_idx <= NONE_INDEX;
                end
            endcase
        end
    end

    assign o_valid           = r_out_valid;
    assign o_entry_index     = r_o_idx;
    assign o_is_new          = r_o_new;
    assign o_dropped_full    = r_o_drop;
    assign o_name_uncloaked  = r_o_uncl;
    assign o_total_count     = r_o_total;
    assign o_band_count      = r_o_band;
    assign o_strongest_index = r_o_strong;
    assign o_busiest_channel = r_o_busy;
    assign o_channel_count   = r_o_chcnt;

    // table never overfills
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // a record either matches or appends, never both
    a_match_xor_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> !(r_found && r_append))
        else $error("record both matched and appended");

    // a dropped record only happens on a full table
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_cmd == CMD_RECORD && !r_found && !r_append)
        |-> (r_total == CW'(TABLE_DEPTH)))
        else $error("record dropped with room left");

    // walks start aligned with the head entry
    a_step_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> (r_step == '0))
        else $error("ring left rotated");

endmodule

>>> rtl/ast_cell.sv
// one ring cell: holds one entry and its channel occupancy count
module ast_cell #(
    parameter int CW = 7
) (
    input  logic              i_clk,
    input  logic              i_shift,
    input  logic              i_clr_cnt,
    input  logic              i_bc_en,
    input  logic [7:0]        i_bc_chan,
    input  ast_pkg::t_entry   i_entry,
    input  logic [CW-1:0]     i_cnt,
    output ast_pkg::t_entry   o_entry,
    output logic [CW-1:0]     o_cnt
);
    import ast_pkg::*;

    t_entry        r_entry;
    logic [CW-1:0] r_cnt;

    // take the neighbor's entry, counting it when its channel is broadcast, or clear the count
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_entry;
            if (i_bc_en && (i_entry.chan == i_bc_chan)) begin
                r_cnt <= i_cnt + CW'(1);
            end else begin
                r_cnt <= i_cnt;
            end
        end else if (i_clr_cnt) begin
            r_cnt <= '0;
        end
    end

    assign o_entry = r_entry;
    assign o_cnt   = r_cnt;

endmodule

>>> tb/sv/tb_top.sv
// testbench for the access point scan table: directed rows, then random traffic
`timescale 1ns / 1ps

module tb_top;
    import ast_pkg::*;

    localparam int DEPTH = 64;

    typedef struct {
        logic [1:0]        cmd;
        logic [47:0]       bssid;
        logic [7:0]        chan;
        logic signed [7:0] rssi;
        logic [31:0]       sec;
        logic [7:0]        nlen;
        logic              band;
    } t_scan_item;

    typedef struct packed {
        logic [6:0] idx;
        logic       is_new;
        logic       dropped;
        logic       uncloaked;
        logic [6:0] total;
        logic [6:0] band_cnt;
        logic [6:0] strongest;
        logic [7:0] busiest;
        logic [6:0] chan_cnt;
    } t_scan_result;

    // directed row: item plus an optional typed-in result
    typedef struct {
        t_scan_item   item;
        bit           typed;
        t_scan_result res;
    } t_scan_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_command = CMD_NOP;
    logic [47:0] i_bssid = '0;
    logic [7:0]  i_channel = '0;
    logic signed [7:0] i_rssi = '0;
    logic [31:0] i_security_code = '0;
    logic [7:0]  i_name_length = '0;
    logic        i_query_band = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic signed [6:0] o_entry_index;
    logic        o_is_new;
    logic        o_dropped_full;
    logic        o_name_uncloaked;
    logic [6:0]  o_total_count;
    logic [6:0]  o_band_count;
    logic signed [6:0] o_strongest_index;
    logic [7:0]  o_busiest_channel;
    logic [6:0]  o_channel_count;

    // predictor copy of the table
    logic [47:0]       ap_addr [DEPTH];
    logic [7:0]        ap_chan [DEPTH];
    logic signed [7:0] ap_sig [DEPTH];
    logic [31:0]       ap_sec [DEPTH];
    logic              ap_named [DEPTH];
    int                ap_total = 0;

    t_scan_result pending_results[$];
    logic [47:0]  key_pool [96];
    int           err_count = 0;
    bit           stim_done = 1'b0;

    ap_scan_table_core #(.TABLE_DEPTH(DEPTH)) i_dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic int find_ap(logic [47:0] key);
        for (int i = 0; i < ap_total; i++)
            if (ap_addr[i] == key) return i;
        return -1;
    endfunction

    function automatic int count_on_chan(logic [7:0] ch);
        int n;
        n = 0;
        for (int i = 0; i < ap_total; i++)
            if (ap_chan[i] == ch) n++;
        return n;
    endfunction

    // updates the table copy and returns the result the item should give
    function automatic t_scan_result apply_scan_item(t_scan_item it);
        t_scan_result r;
        int f, best, best_cnt, c;
        r = '0;
        r.idx = NONE_INDEX;
        r.strongest = NONE_INDEX;
        case (it.cmd)
            CMD_CLEAR: ap_total = 0;
            CMD_RECORD: begin
                f = find_ap(it.bssid);
                if (f >= 0) begin
                    if (!ap_named[f] && it.nlen != 0) begin
                        ap_named[f] = 1'b1;
                        r.uncloaked = 1'b1;
                    end
                    ap_sig[f] = it.rssi;
                    ap_chan[f] = it.chan;
                    ap_sec[f] = it.sec;
                    r.idx = 7'(f);
                end else if (ap_total >= DEPTH) begin
                    r.dropped = 1'b1;
                end else begin
                    ap_addr[ap_total] = it.bssid;
                    ap_chan[ap_total] = it.chan;
                    ap_sig[ap_total] = it.rssi;
                    ap_sec[ap_total] = it.sec;
                    ap_named[ap_total] = (it.nlen != 0);
                    r.idx = 7'(ap_total);
                    r.is_new = 1'b1;
                    ap_total++;
                end
            end
            CMD_QUERY: begin
                f = find_ap(it.bssid);
                if (f >= 0) r.idx = 7'(f);
                best = -1;
                best_cnt = 0;
                for (int i = 0; i < ap_total; i++) begin
                    if ((ap_chan[i] >= BAND5_FIRST) != it.band) continue;
                    r.band_cnt++;
                    if (best < 0 || ap_sig[i] > ap_sig[best]) best = i;
                    c = count_on_chan(ap_chan[i]);
                    if (c > best_cnt) begin
                        best_cnt = c;
                        r.busiest = ap_chan[i];
                    end
                end
                if (best >= 0) r.strongest = 7'(best);
                r.chan_cnt = 7'(count_on_chan(it.chan));
            end
            default: ;
        endcase
        r.total = 7'(ap_total);
        return r;
    endfunction

    function automatic t_scan_row mk_row(logic [1:0] cmd, logic [47:0] key, logic [7:0] ch,
                                         logic [7:0] rssi, logic [31:0] sec, logic [7:0] nlen,
                                         logic band);
        t_scan_row row;
        row.item = '{cmd, key, ch, rssi, sec, nlen, band};
        row.typed = 1'b0;
        row.res = '0;
        return row;
    endfunction

    function automatic t_scan_row mk_typed(t_scan_row row, logic [6:0] idx, logic is_new,
                                           logic unc, logic [6:0] total, logic [6:0] bc,
                                           logic [6:0] st, logic [7:0] busy,
                                           logic [6:0] cc);
        row.typed = 1'b1;
        row.res = '{idx, is_new, 1'b0, unc, total, bc, st, busy, cc};
        return row;
    endfunction

    function automatic logic [7:0] pick_chan();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd6;
            3: return 8'd11;
            4: return 8'd35;
            5: return 8'd36;
            6: return 8'd149;
            7: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_scan_item rand_scan_item();
        t_scan_item it;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 2) it.cmd = CMD_CLEAR;
        else if (sel < 5) it.cmd = CMD_NOP;
        else if (sel < 65) it.cmd = CMD_RECORD;
        else it.cmd = CMD_QUERY;
        if ($urandom_range(0, 9) < 7) it.bssid = key_pool[$urandom_range(0, 95)];
        else it.bssid = {16'($urandom), 32'($urandom)};
        it.chan = pick_chan();
        it.rssi = 8'($urandom);
        it.sec = $urandom;
        it.nlen = $urandom_range(0, 1) ? 8'($urandom) : 8'd0;
        it.band = 1'($urandom);
        return it;
    endfunction

    // present one item and hold it until taken
    task automatic send_scan_item(t_scan_item it, t_scan_result res);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 :
              ($urandom_range(0, 19) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= it.cmd;
        i_bssid <= it.bssid;
        i_channel <= it.chan;
        i_rssi <= it.rssi;
        i_security_code <= it.sec;
        i_name_length <= it.nlen;
        i_query_band <= it.band;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_results.push_back(res);
    endtask

    task automatic check_field(string fname, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h got %0h", $time, fname, want, got);
            err_count++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_scan_result w;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item, index %0h", $time, o_entry_index);
                err_count++;
            end else begin
                w = pending_results.pop_front();
                check_field("entry_index", w.idx, $unsigned(o_entry_index));
                check_field("is_new", w.is_new, o_is_new);
                check_field("dropped_full", w.dropped, o_dropped_full);
                check_field("name_uncloaked", w.uncloaked, o_name_uncloaked);
                check_field("total_count", w.total, o_total_count);
                check_field("band_count", w.band_cnt, o_band_count);
                check_field("strongest_index", w.strongest, $unsigned(o_strongest_index));
                check_field("busiest_channel", w.busiest, o_busiest_channel);
                check_field("channel_count", w.chan_cnt, o_channel_count);
            end
        end
    end

    // receiver stalls: mostly short, some long, with busy-free stretches
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400) : $urandom_range(1, 5);
                repeat (n) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 60)) @(posedge i_clk);
            end
        end
    end

    // stimulus
    initial begin
        t_scan_row    rows[$];
        t_scan_item   it;
        t_scan_result r;
        for (int k = 0; k < 96; k++) key_pool[k] = {16'($urandom), 32'($urandom)};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rows.push_back(mk_typed(mk_row(CMD_QUERY, 48'h0, 8'd0, 8'h00, 0, 0, 1'b0),
                                NONE_INDEX, 0, 0, 0, 0, NONE_INDEX, 0, 0));
        rows.push_back(mk_typed(mk_row(CMD_NOP, '1, 8'd255, 8'h7F, '1, 8'd255, 1'b1),
                                NONE_INDEX, 0, 0, 0, 0, NONE_INDEX, 0, 0));
        rows.push_back(mk_typed(mk_row(CMD_RECORD, 48'h0, 8'd0, 8'h80, 0, 8'd0, 1'b0),
                                7'd0, 1, 0, 7'd1, 0, NONE_INDEX, 0, 0));
        rows.push_back(mk_typed(mk_row(CMD_RECORD, '1, 8'd255, 8'h7F, '1, 8'd255, 1'b1),
                                7'd1, 1, 0, 7'd2, 0, NONE_INDEX, 0, 0));
        // unnamed entry gets a name
        rows.push_back(mk_typed(mk_row(CMD_RECORD, 48'h0, 8'd0, 8'h80, 0, 8'd5, 1'b0),
                                7'd0, 0, 1, 7'd2, 0, NONE_INDEX, 0, 0));
        rows.push_back(mk_typed(mk_row(CMD_QUERY, 48'h0, 8'd0, 8'h00, 0, 0, 1'b0),
                                7'd0, 0, 0, 7'd2, 7'd1, 7'd0, 8'd0, 7'd1));
        rows.push_back(mk_typed(mk_row(CMD_QUERY, '1, 8'd255, 8'h00, 0, 0, 1'b1),
                                7'd1, 0, 0, 7'd2, 7'd1, 7'd1, 8'd255, 7'd1));
        // band edge, equal signals, busiest channel ties
        rows.push_back(mk_row(CMD_RECORD, 48'h1, 8'd35, 8'h10, 32'h5, 8'd1, 1'b0));
        rows.push_back(mk_row(CMD_RECORD, 48'h2, 8'd36, 8'h10, 32'h6, 8'd0, 1'b0));
        rows.push_back(mk_row(CMD_RECORD, 48'h3, 8'd36, 8'h10, 32'h7, 8'd0, 1'b0));
        rows.push_back(mk_row(CMD_RECORD, 48'h4, 8'd35, 8'h10, 32'h8, 8'd0, 1'b0));
        rows.push_back(mk_row(CMD_RECORD, 48'h5, 8'd1, 8'h7F, 32'h9, 8'd0, 1'b0));
        rows.push_back(mk_row(CMD_QUERY, 48'h3, 8'd36, 8'h00, 0, 0, 1'b1));
        rows.push_back(mk_row(CMD_QUERY, 48'h9, 8'd35, 8'h00, 0, 0, 1'b0));
        rows.push_back(mk_row(CMD_RECORD, 48'h3, 8'd149, 8'hF0, 32'hA, 8'd0, 1'b0));
        rows.push_back(mk_row(CMD_QUERY, 48'h3, 8'd149, 8'h00, 0, 0, 1'b1));
        rows.push_back(mk_typed(mk_row(CMD_CLEAR, '1, 8'd0, 8'h00, 0, 0, 1'b0),
                                NONE_INDEX, 0, 0, 0, 0, NONE_INDEX, 0, 0));
        rows.push_back(mk_typed(mk_row(CMD_QUERY, '1, 8'd255, 8'h00, 0, 0, 1'b1),
                                NONE_INDEX, 0, 0, 0, 0, NONE_INDEX, 0, 0));

        foreach (rows[k]) begin
            r = apply_scan_item(rows[k].item);
            send_scan_item(rows[k].item, rows[k].typed ? rows[k].res : r);
        end

        // random part in segments, each opened by a clear so the table refills
        for (int n = 0; n < 1300; n++) begin
            if (n % 260 == 0) begin
                it = rand_scan_item();
                it.cmd = CMD_CLEAR;
            end else begin
                it = rand_scan_item();
            end
            if (n == 650) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            r = apply_scan_item(it);
            send_scan_item(it, r);
        end
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        stim_done = 1'b1;
        if (err_count == 0 && pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // run limit
    initial begin
        #40ms;
        if (!stim_done) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule

>>> files.f
rtl/ast_pkg.sv
rtl/ast_cell.sv
rtl/ap_scan_table_core.sv
tb/sv/tb_top.sv
